/* hw/rtl/prps_pkg.sv */
// ----------------------------------------------------------------------------
// prps_pkg
// Types and constants for the power rail protection supervisor.
// ----------------------------------------------------------------------------
package prps_pkg;

    localparam int RAIL_SLOTS  = 16;
    localparam int VOLT_W      = 16;
    localparam int TEMP_W      = 12;
    localparam int COUNT_W     = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_OVER_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNDER_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAT_ON     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAT_OFF    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 3'd4;

    localparam logic [VOLT_W-1:0]  OVER_LIMIT_RST  = 16'hFFFF;
    localparam logic [VOLT_W-1:0]  UNDER_LIMIT_RST = 16'h0000;
    localparam logic [TEMP_W-1:0]  HEAT_ON_RST     = 12'h000;
    localparam logic [TEMP_W-1:0]  HEAT_OFF_RST    = 12'hFFF;
    localparam logic [COUNT_W-1:0] RETRY_LIMIT_RST = 4'd3;

    typedef struct packed {
        logic [VOLT_W-1:0]     battery_voltage;
        logic [TEMP_W-1:0]     battery_temp_raw;
        logic [RAIL_SLOTS-1:0] rail_faults;
    } t_in;

    typedef struct packed {
        logic                  charger_enable;
        logic [RAIL_SLOTS-1:0] rail_enable;
        logic [RAIL_SLOTS-1:0] rail_retry_pulse;
        logic [RAIL_SLOTS-1:0] rail_permanent_fault;
        logic                  heater_enable;
    } t_out;

    typedef struct packed {
        logic enable;
        logic pulse;
        logic perm;
    } t_rail_res;

endpackage

/* hw/rtl/prps_rail.sv */
// ----------------------------------------------------------------------------
// prps_rail
// Retry counter and switch decision for one load rail.
// ----------------------------------------------------------------------------
module prps_rail (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_fault,
    input  logic                          i_under,
    input  logic [prps_pkg::COUNT_W-1:0]  i_limit,
    output prps_pkg::t_rail_res           o_res
);
    import prps_pkg::*;

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               below;

    assign below = r_count < i_limit;

    always_comb begin
        n_count = r_count;
        o_res   = '0;
        if (i_fault) begin
            if (below) begin
                if (!i_under) begin
                    o_res.pulse  = 1'b1;
                    o_res.enable = 1'b1;
                    n_count      = r_count + COUNT_W'(1);
                end
            end else begin
                o_res.perm = 1'b1;
            end
        end else begin
            n_count      = '0;
            o_res.enable = !i_under;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_step) begin
            r_count <= n_count;
        end
    end

endmodule

/* hw/rtl/power_rail_protection_supervisor.sv */
// ----------------------------------------------------------------------------
// power_rail_protection_supervisor
// Charger, load rail retry and battery heater control, one tick per transaction.
// ----------------------------------------------------------------------------
// Each accepted transaction's result is registered in the output register in the next cycle.
// Throughput: 1 transaction per cycle; input is ready while the output register
// is empty or being drained in the same cycle.
// Reset: synchronous active low; clears retry counts, heater state, output
// valid and loads the limit registers with their defaults.
module power_rail_protection_supervisor #(
    parameter int NUM_RAILS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  prps_pkg::t_in                     i_data,
    output logic                              o_valid,
    input  logic                              i_ready,
    output prps_pkg::t_out                    o_data,
    input  logic                              i_cfg_we,
    input  logic [prps_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [prps_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import prps_pkg::*;

    localparam int ACTIVE_RAILS = (NUM_RAILS > RAIL_SLOTS) ? RAIL_SLOTS : NUM_RAILS;

    logic [VOLT_W-1:0]  r_over_limit;
    logic [VOLT_W-1:0]  r_under_limit;
    logic [TEMP_W-1:0]  r_heat_on;
    logic [TEMP_W-1:0]  r_heat_off;
    logic [COUNT_W-1:0] r_retry_limit;

    logic  r_heater;
    logic  n_heater;
    logic  r_valid;
    t_out  r_out;
    t_out  n_out;
    logic  accept;
    logic  under;

    t_rail_res rail_res [RAIL_SLOTS];

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign under   = i_data.battery_voltage < r_under_limit;
    assign o_valid = r_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_over_limit  <= OVER_LIMIT_RST;
            r_under_limit <= UNDER_LIMIT_RST;
            r_heat_on     <= HEAT_ON_RST;
            r_heat_off    <= HEAT_OFF_RST;
            r_retry_limit <= RETRY_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OVER_LIMIT:  r_over_limit  <= i_cfg_wdata[VOLT_W-1:0];
                CFG_UNDER_LIMIT: r_under_limit <= i_cfg_wdata[VOLT_W-1:0];
                CFG_HEAT_ON:     r_heat_on     <= i_cfg_wdata[TEMP_W-1:0];
                CFG_HEAT_OFF:    r_heat_off    <= i_cfg_wdata[TEMP_W-1:0];
                CFG_RETRY_LIMIT: r_retry_limit <= i_cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < RAIL_SLOTS; g++) begin : g_rail
            if (g < ACTIVE_RAILS) begin : g_on
                prps_rail u_rail (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_step  (accept),
                    .i_fault (i_data.rail_faults[g]),
                    .i_under (under),
                    .i_limit (r_retry_limit),
                    .o_res   (rail_res[g])
                );
            end else begin : g_off
                assign rail_res[g] = '0;
            end
        end
    endgenerate

    always_comb begin
        n_heater = r_heater;
        if (i_data.battery_temp_raw < r_heat_on) begin
            n_heater = 1'b1;
        end else if (i_data.battery_temp_raw > r_heat_off) begin
            n_heater = 1'b0;
        end
        n_out = '0;
        n_out.charger_enable = !(i_data.battery_voltage > r_over_limit);
        n_out.heater_enable  = n_heater;
        for (int k = 0; k < RAIL_SLOTS; k++) begin
            n_out.rail_enable[k]          = rail_res[k].enable;
            n_out.rail_retry_pulse[k]     = rail_res[k].pulse;
            n_out.rail_permanent_fault[k] = rail_res[k].perm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_heater <= 1'b0;
        end else begin
            if (accept) begin
                r_valid  <= 1'b1;
                r_heater <= n_heater;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    a_pulse_perm_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ((r_out.rail_retry_pulse & r_out.rail_permanent_fault) == '0))
        else $error("retry pulse and permanent fault on the same rail");

    a_pulse_enables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ((r_out.rail_retry_pulse & ~r_out.rail_enable) == '0))
        else $error("retry pulse on a rail left off");

    a_perm_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ((r_out.rail_permanent_fault & r_out.rail_enable) == '0))
        else $error("permanently faulted rail switched on");

    a_heater_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_out.heater_enable == r_heater))
        else $error("heater output disagrees with heater state");

endmodule
